// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros: clocked on i_clk, muted while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in every cycle outside reset
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that a trigger in one cycle implies a condition in the next cycle
`define ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ----- design/msqd_pkg.sv -----
// ----------------------------------------------------------------------------
// msqd_pkg
// Types and constants shared by the job dispatcher modules.
// ----------------------------------------------------------------------------
`default_nettype none

package msqd_pkg;

    // Fixed field widths
    localparam int TAG_W      = 16;
    localparam int SRV_W      = 4;
    localparam int CNT_OUT_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int LIMIT_W    = 7;
    localparam int SCOUNT_W   = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LCFS_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT = 2'd2;

    // Command codes
    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_STATUS = 1'b1;

    // Result action codes
    typedef enum logic [1:0] {
        ACT_QUEUED     = 2'd0,
        ACT_DISPATCHED = 2'd1,
        ACT_DROPPED    = 2'd2,
        ACT_NONE       = 2'd3
    } t_action;

    // Requests to the job store
    typedef struct packed {
        logic push;
        logic pop;
        logic lcfs;
    } t_queue_req;

    // Requests to the server pool
    typedef struct packed {
        logic take;     // mark the lowest idle server busy
        logic update;   // write one server's busy bit
        logic upd_val;  // value written on update
    } t_pool_req;

endpackage

`default_nettype wire

// ----- design/msqd_server_pool.sv -----
// ----------------------------------------------------------------------------
// msqd_server_pool
// Busy bit per server and a priority encoder that finds the lowest idle one.
// ----------------------------------------------------------------------------
`default_nettype none

module msqd_server_pool #(
    parameter int MAX_SERVERS = 16,
    parameter int SIDX_W      = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire msqd_pkg::t_pool_req        i_req,
    input  wire logic [msqd_pkg::SRV_W-1:0] i_server,
    input  wire logic [6:0]                 i_in_use,
    output logic                            o_found,
    output logic [SIDX_W-1:0]               o_idle_idx
);
    import msqd_pkg::*;

    logic [MAX_SERVERS-1:0] r_busy_bits;
    logic [MAX_SERVERS-1:0] n_busy_bits;

    // Find the lowest idle server in use
    always_comb begin
        o_found    = 1'b0;
        o_idle_idx = '0;
        for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
            if (!r_busy_bits[i] && (i < int'(i_in_use))) begin
                o_found    = 1'b1;
                o_idle_idx = SIDX_W'(i);
            end
        end
    end

    // Apply a take or a status write
    always_comb begin
        n_busy_bits = r_busy_bits;
        for (int i = 0; i < MAX_SERVERS; i++) begin
            if (i_req.take && o_found && (int'(o_idle_idx) == i)) begin
                n_busy_bits[i] = 1'b1;
            end
            if (i_req.update && (int'(i_server) == i)) begin
                n_busy_bits[i] = i_req.upd_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_bits <= '0;
        end else begin
            r_busy_bits <= n_busy_bits;
        end
    end

endmodule

`default_nettype wire

// ----- design/msqd_job_queue.sv -----
// ----------------------------------------------------------------------------
// msqd_job_queue
// Ring store of waiting job tags with head, tail and count; pops from the
// head (oldest) or the tail (newest). Read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module msqd_job_queue #(
    parameter int DEPTH = 64,
    parameter int CW    = 7
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire msqd_pkg::t_queue_req       i_req,
    input  wire logic [msqd_pkg::TAG_W-1:0] i_wdata,
    output logic [CW-1:0]                   o_count,
    output logic [msqd_pkg::TAG_W-1:0]      o_rd_data
);
    import msqd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [TAG_W-1:0] mem [DEPTH];
    logic [PW-1:0]    r_head;
    logic [PW-1:0]    r_tail;
    logic [CW-1:0]    r_count;
    logic [PW-1:0]    n_head;
    logic [PW-1:0]    n_tail;
    logic [CW-1:0]    n_count;
    logic [PW-1:0]    tail_next;
    logic [PW-1:0]    tail_prev;
    logic [PW-1:0]    head_next;
    logic [PW-1:0]    rd_addr;

    // Ring neighbours of the pointers
    assign tail_next = (r_tail == LAST) ? '0 : r_tail + PW'(1);
    assign tail_prev = (r_tail == '0) ? LAST : r_tail - PW'(1);
    assign head_next = (r_head == LAST) ? '0 : r_head + PW'(1);
    assign rd_addr   = i_req.lcfs ? tail_prev : r_head;

    // Advance pointers and count
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_req.push) begin
            n_tail  = tail_next;
            n_count = r_count + CW'(1);
        end else if (i_req.pop) begin
            if (i_req.lcfs) begin
                n_tail = tail_prev;
            end else begin
                n_head = head_next;
            end
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Write on push, registered read on pop
    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            mem[r_tail] <= i_wdata;
        end
        if (i_req.pop) begin
            o_rd_data <= mem[rd_addr];
        end
    end

    assign o_count = r_count;

    `ASSERT_ALWAYS(a_no_push_pop, !(i_req.push && i_req.pop), "push and pop in one beat")
    `ASSERT_NEXT(a_pop_dec, i_req.pop && !i_req.push, r_count == $past(r_count) - CW'(1), "pop did not decrement count")

endmodule

`default_nettype wire

// ----- design/multi_server_queue_dispatcher.sv -----
// ----------------------------------------------------------------------------
// multi_server_queue_dispatcher
// Job dispatcher: lowest idle server gets a job, else a bounded FCFS/LCFS
// store holds it; idle status updates pull a waiting job.
// ----------------------------------------------------------------------------
// One command is taken per clock (busy is low except during and just after
// reset). The result of a command taken at a clock edge sits on the o_
// result ports, marked by o_valid, for exactly the next cycle; the receiver
// cannot stall, so it must take the beat then. The rate of one beat per
// clock is set by the combinational decision (priority encode over the busy
// bits plus one store push or pop) and the registered store read that
// supplies a popped tag. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_server_queue_dispatcher #(
    parameter int QUEUE_DEPTH = 64,
    parameter int MAX_SERVERS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            i_command,
    input  wire logic [msqd_pkg::TAG_W-1:0]      i_job_tag,
    input  wire logic [msqd_pkg::SRV_W-1:0]      i_status_server,
    input  wire logic                            i_status_busy,
    // result strobe
    output logic                                 o_valid,
    output logic [1:0]                           o_action,
    output logic [msqd_pkg::SRV_W-1:0]           o_dispatch_server,
    output logic [msqd_pkg::TAG_W-1:0]           o_dispatch_tag,
    output logic [msqd_pkg::CNT_OUT_W-1:0]       o_waiting_count,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [msqd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [msqd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import msqd_pkg::*;

    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int LW     = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int SIDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    // configuration
    logic                r_lcfs_mode;
    logic [LIMIT_W-1:0]  r_queue_limit;
    logic [SCOUNT_W-1:0] r_server_count;

    // control
    logic                r_busy;
    logic                r_valid;

    // result payload
    t_action             r_action;
    logic [SRV_W-1:0]    r_server;
    logic [TAG_W-1:0]    r_tag;
    logic                r_from_queue;

    logic                accept;
    logic [6:0]          in_use;
    logic [6:0]          scount_ext;
    logic [LW-1:0]       limit_in_use;
    logic                queue_full;
    logic                queue_empty;
    logic                srv_in_use;
    logic                idle_found;
    logic [SIDX_W-1:0]   idle_idx;
    logic [CW-1:0]       q_count;
    logic [TAG_W-1:0]    q_rd_data;
    t_queue_req          q_req;
    t_pool_req           p_req;
    t_action             n_action;
    logic [SRV_W-1:0]    n_server;
    logic [TAG_W-1:0]    n_tag;
    logic                n_from_queue;

    assign accept      = start && !busy;
    assign busy        = r_busy;
    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcfs_mode    <= 1'b0;
            r_queue_limit  <= LIMIT_W'(64);
            r_server_count <= SCOUNT_W'(16);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LCFS_MODE:    r_lcfs_mode    <= i_cfg_data[0];
                CFG_QUEUE_LIMIT:  r_queue_limit  <= i_cfg_data[LIMIT_W-1:0];
                CFG_SERVER_COUNT: r_server_count <= i_cfg_data[SCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate server count and queue limit
    assign scount_ext   = 7'(r_server_count);
    assign in_use       = (scount_ext > 7'(MAX_SERVERS)) ? 7'(MAX_SERVERS) : scount_ext;
    assign limit_in_use = (LW'(r_queue_limit) > LW'(QUEUE_DEPTH)) ? LW'(QUEUE_DEPTH)
                                                                   : LW'(r_queue_limit);
    assign queue_full   = LW'(q_count) >= limit_in_use;
    assign queue_empty  = (q_count == '0);
    assign srv_in_use   = 7'(i_status_server) < in_use;

    // Decide the action for this beat
    always_comb begin
        q_req        = '0;
        p_req        = '0;
        q_req.lcfs   = r_lcfs_mode;
        n_action     = ACT_NONE;
        n_server     = '0;
        n_tag        = '0;
        n_from_queue = 1'b0;
        if (accept) begin
            if (i_command == CMD_ARRIVE) begin
                if (idle_found) begin
                    p_req.take = 1'b1;
                    n_action   = ACT_DISPATCHED;
                    n_server   = SRV_W'(idle_idx);
                    n_tag      = i_job_tag;
                end else if (queue_full) begin
                    n_action   = ACT_DROPPED;
                end else begin
                    q_req.push = 1'b1;
                    n_action   = ACT_QUEUED;
                end
            end else if (srv_in_use) begin
                p_req.update  = 1'b1;
                p_req.upd_val = i_status_busy || !queue_empty;
                if (!i_status_busy && !queue_empty) begin
                    q_req.pop    = 1'b1;
                    n_action     = ACT_DISPATCHED;
                    n_server     = i_status_server;
                    n_from_queue = 1'b1;
                end
            end
        end
    end

    msqd_server_pool #(
        .MAX_SERVERS (MAX_SERVERS),
        .SIDX_W      (SIDX_W)
    ) u_pool (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (p_req),
        .i_server   (i_status_server),
        .i_in_use   (in_use),
        .o_found    (idle_found),
        .o_idle_idx (idle_idx)
    );

    msqd_job_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (q_req),
        .i_wdata   (i_job_tag),
        .o_count   (q_count),
        .o_rd_data (q_rd_data)
    );

    // Hold control and the result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action     <= n_action;
            r_server     <= n_server;
            r_tag        <= n_tag;
            r_from_queue <= n_from_queue;
        end
    end

    // Drive result ports; a popped tag comes from the store read register
    assign o_valid           = r_valid;
    assign o_action          = r_action;
    assign o_dispatch_server = r_server;
    assign o_dispatch_tag    = r_from_queue ? q_rd_data : r_tag;
    assign o_waiting_count   = CNT_OUT_W'(q_count);

    `ASSERT_NEXT(a_result_follows, accept, o_valid, "accepted beat gave no result")
    `ASSERT_ALWAYS(a_drop_clean, !(o_valid && (r_action == ACT_DROPPED)) || (o_dispatch_tag == '0 && o_dispatch_server == '0), "dropped beat carries a tag")

endmodule

`default_nettype wire
